// File: rtl/lfu_cache_table_unit_macros.svh
// Assertion macros of the cache table unit, used by the sequencer
`ifndef LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define LFU_CACHE_TABLE_UNIT_MACROS_SVH
// Same-cycle implication, disabled during reset
`define LFU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu assertion failed");
// Next-cycle implication, disabled during reset
`define LFU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu assertion failed");
`endif

// File: rtl/lfu_pkg.sv
// Shared types and constants of the cache table unit
package lfu_pkg;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam logic [4:0] CAP_RESET = 5'd16;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;
endpackage

// File: rtl/lfu_cache_table_unit.sv
// Top level of the LFU cache table unit with least-recent tie break
// Usage:
//   Input: drive in_opcode (0 get, 1 put), in_key, in_value and raise start;
//   the beat is taken at a rising edge with start high and busy low.
//   Result: out_valid is high for exactly one cycle with out_hit,
//   out_read_value, out_evicted and out_evicted_key; it is taken at that
//   edge and the receiver cannot stall it.
//   Configuration: cfg_wr_en with cfg_wr_data writes capacity; write only
//   while busy is low and no result is pending.
// Timing:
//   After the accepting edge the datapath scans one entry per cycle over
//   all CAPACITY entry cells, then performs the update in ST_UPDATE.
//   out_valid is registered from the update command; busy is low again in
//   the same cycle as out_valid, so the next beat can be taken while the
//   result shows. The scan over the entry cells sets the time per beat.
// Reset:
//   rst_n low (synchronous) empties the table, sets capacity to 16 and
//   drops any beat in flight.
module lfu_cache_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_read_value,
  output logic        out_evicted,
  output logic [31:0] out_evicted_key,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);
  import lfu_pkg::*;

  cmd_t    cmd;
  status_t status;

  lfu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  lfu_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );
endmodule

// File: rtl/lfu_ctrl.sv
// Sequencer of the cache table unit: load, entry scan, update
`include "lfu_cache_table_unit_macros.svh"
module lfu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output lfu_pkg::cmd_t    cmd,
  input  lfu_pkg::status_t status
);
  import lfu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LFU_ASSERT_NXT(a_accept_busy, start && !busy, busy && state_r == ST_SCAN)
  `LFU_ASSERT_NXT(a_update_once, cmd.update, !busy)
  `LFU_ASSERT_NXT(a_scan_end, cmd.scan && status.scan_last, cmd.update)
endmodule

// File: rtl/lfu_dp.sv
// Datapath of the cache table unit: entry cells, scan registers, result register
module lfu_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfu_pkg::cmd_t       cmd,
  output lfu_pkg::status_t    status,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic                in_opcode,
  input  logic [31:0]         in_key,
  input  logic [31:0]         in_value,
  output logic                out_valid,
  output logic                out_hit,
  output logic [31:0]         out_read_value,
  output logic                out_evicted,
  output logic [31:0]         out_evicted_key
);
  import lfu_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = IW + 1;
  localparam int CW = (OW > 5) ? OW : 5;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_MAX = CW'(CAPACITY);

  logic [4:0]    cfg_capacity_r;

  logic          e_valid_r [CAPACITY];
  logic [31:0]   e_key_r   [CAPACITY];
  logic [31:0]   e_data_r  [CAPACITY];
  logic [31:0]   e_count_r [CAPACITY];
  logic [IW-1:0] e_rank_r  [CAPACITY];

  logic          op_r;
  logic [31:0]   key_r, val_r;
  logic [IW-1:0] idx_r;
  logic          m_found_r, v_valid_r, f_found_r;
  logic [IW-1:0] m_idx_r, v_idx_r, f_idx_r;
  logic [IW-1:0] m_rank_r, v_rank_r;
  logic [31:0]   m_data_r, v_key_r, v_count_r;
  logic [OW-1:0] occ_r;

  logic          out_valid_r, out_hit_r, out_evicted_r;
  logic [31:0]   out_read_value_r, out_evicted_key_r;

  logic          cur_valid, better;
  logic [CW-1:0] cap_ext, eff_cap;
  logic          cap_nz, do_touch, do_ins, do_ev, have_f;
  logic [IW-1:0] f_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_capacity_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cfg_capacity_r <= cfg_wr_data;
    end
  end

  assign cap_ext = CW'(cfg_capacity_r);
  assign eff_cap = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;
  assign cap_nz  = (eff_cap != '0);

  assign status.scan_last = (idx_r == LAST_IDX);

  assign cur_valid = e_valid_r[idx_r];
  assign better    = !v_valid_r || (e_count_r[idx_r] < v_count_r) ||
                     ((e_count_r[idx_r] == v_count_r) && (e_rank_r[idx_r] > v_rank_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      key_r     <= in_key;
      val_r     <= in_value;
      idx_r     <= '0;
      m_found_r <= 1'b0;
      v_valid_r <= 1'b0;
      f_found_r <= 1'b0;
      occ_r     <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + IW'(1);
      if (cur_valid) begin
        occ_r <= occ_r + OW'(1);
        if (!m_found_r && e_key_r[idx_r] == key_r) begin
          m_found_r <= 1'b1;
          m_idx_r   <= idx_r;
          m_rank_r  <= e_rank_r[idx_r];
          m_data_r  <= e_data_r[idx_r];
        end
        if (better) begin
          v_valid_r <= 1'b1;
          v_idx_r   <= idx_r;
          v_rank_r  <= e_rank_r[idx_r];
          v_count_r <= e_count_r[idx_r];
          v_key_r   <= e_key_r[idx_r];
        end
      end else if (!f_found_r) begin
        f_found_r <= 1'b1;
        f_idx_r   <= idx_r;
      end
    end
  end

  assign do_touch = m_found_r && (op_r == OP_GET || cap_nz);
  assign do_ins   = (op_r == OP_PUT) && cap_nz && !m_found_r;
  assign do_ev    = do_ins && (CW'(occ_r) >= eff_cap) && v_valid_r;
  assign have_f   = do_ins && (do_ev || f_found_r);
  assign f_sel    = (do_ev && !(f_found_r && f_idx_r < v_idx_r)) ? v_idx_r : f_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        e_valid_r[i] <= 1'b0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_touch) begin
          if (IW'(i) == m_idx_r) begin
            e_rank_r[i] <= '0;
            if (e_count_r[i] != COUNT_MAX) begin
              e_count_r[i] <= e_count_r[i] + 32'd1;
            end
            if (op_r == OP_PUT) begin
              e_data_r[i] <= val_r;
            end
          end else if (e_valid_r[i] && e_rank_r[i] < m_rank_r) begin
            e_rank_r[i] <= e_rank_r[i] + IW'(1);
          end
        end else if (have_f) begin
          if (IW'(i) == f_sel) begin
            e_valid_r[i] <= 1'b1;
            e_key_r[i]   <= key_r;
            e_data_r[i]  <= val_r;
            e_count_r[i] <= 32'd1;
            e_rank_r[i]  <= '0;
          end else if (do_ev && IW'(i) == v_idx_r) begin
            e_valid_r[i] <= 1'b0;
          end else if (e_valid_r[i] && !(do_ev && e_rank_r[i] > v_rank_r)) begin
            e_rank_r[i] <= e_rank_r[i] + IW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r         <= m_found_r;
      out_read_value_r  <= (op_r == OP_GET && m_found_r) ? m_data_r : 32'd0;
      out_evicted_r     <= do_ev;
      out_evicted_key_r <= do_ev ? v_key_r : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;
endmodule
